@@ src/dtag_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtag_pkg
// Shared types, codes and constants of the DMA traffic address generator.
// ----------------------------------------------------------------------------
package dtag_pkg;

   // Default sizes of the top-level parameters
   localparam int READ_CHUNK_DEF  = 512;
   localparam int WRITE_CHUNK_DEF = 256;
   localparam int ADDR_BITS_DEF   = 48;

   // Fixed field widths
   localparam int PORT_ADDR_BITS = 48;
   localparam int SIZE_BITS      = 32;
   localparam int XFER_BITS      = 24;
   localparam int COUNT_BITS     = 32;
   localparam int BYTE_BITS      = 40;
   localparam int LEN_BITS       = 10;
   localparam int LFSR_BITS      = 31;
   localparam int CSR_IDX_BITS   = 3;
   localparam int CSR_DATA_BITS  = 48;
   localparam int WIDE_BITS      = 64;

   // Address step of the sequential-by-512 pattern and random page alignment
   localparam int SEQ512_STEP = 512;
   localparam int PAGE_BITS   = 12;

   // Register reset values
   localparam logic [SIZE_BITS-1:0]  REGION_SIZE_RST = 32'd8388608;
   localparam logic [XFER_BITS-1:0]  XFER_LEN_RST    = 24'd256;
   localparam logic [LFSR_BITS-1:0]  SEED_RST        = 31'd1;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      REG_REGION_BASE     = 3'd0,
      REG_REGION_SIZE     = 3'd1,
      REG_TRANSFER_LENGTH = 3'd2,
      REG_WRITE_MODE      = 3'd3,
      REG_ACCESS_PATTERN  = 3'd4,
      REG_ITERATION_LIMIT = 3'd5,
      REG_RANDOM_SEED     = 3'd6
   } reg_index_type;

   typedef enum logic [1:0] {
      PAT_SEQ    = 2'd0,
      PAT_SEQ512 = 2'd1,
      PAT_FIXED  = 2'd2,
      PAT_RANDOM = 2'd3
   } pattern_type;

   typedef enum logic {
      OPC_START    = 1'b0,
      OPC_COMPLETE = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      STAT_ISSUED   = 2'd0,
      STAT_FINISHED = 2'd1,
      STAT_ERROR    = 2'd2,
      STAT_IGNORED  = 2'd3
   } rsp_status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_ADDR,
      ST_EMIT
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_START,
      OP_IGNORE,
      OP_FAIL,
      OP_UPDATE,
      OP_DIV_STEP,
      OP_RAND_ADDR
   } dp_op_type;

   typedef struct packed {
      logic [PORT_ADDR_BITS-1:0] region_base;
      logic [SIZE_BITS-1:0]      region_size;
      logic [XFER_BITS-1:0]      transfer_length;
      logic                      write_mode;
      pattern_type               access_pattern;
      logic [COUNT_BITS-1:0]     iteration_limit;
      logic [LFSR_BITS-1:0]      random_seed;
   } cfg_type;

   typedef struct packed {
      logic      capture;
      dp_op_type op;
      logic      emit;
   } cmd_type;

   typedef struct packed {
      opcode_type opcode;
      logic       failed;
      logic       running;
      logic       random_div;
      logic       div_last;
      logic       out_free;
   } sts_type;

   // One step of the x^31 + x^28 + 1 shift register
   function automatic logic [LFSR_BITS-1:0] lfsr_next(input logic [LFSR_BITS-1:0] s);
      logic fb;
      fb = s[30] ^ s[27];
      return {s[LFSR_BITS-2:0], fb};
   endfunction

endpackage
`default_nettype wire

@@ src/dtag_req_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtag_req_if
// Request channel: start and completion beats into the generator.
// ----------------------------------------------------------------------------
interface dtag_req_if;
   logic                          valid;
   logic                          ready;
   logic                          opcode;
   logic [dtag_pkg::LEN_BITS-1:0] bytes_done;
   logic                          failed;

   modport source (output valid, output opcode, output bytes_done, output failed,
                   input ready);
   modport sink (input valid, input opcode, input bytes_done, input failed,
                 output ready);
endinterface
`default_nettype wire

@@ src/dtag_rsp_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtag_rsp_if
// Response channel: one result beat per request beat.
// ----------------------------------------------------------------------------
interface dtag_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [dtag_pkg::PORT_ADDR_BITS-1:0] request_address;
   logic [dtag_pkg::LEN_BITS-1:0]       request_length;
   logic                                request_write;
   logic [1:0]                          status;
   logic [dtag_pkg::COUNT_BITS-1:0]     transaction_total;
   logic [dtag_pkg::BYTE_BITS-1:0]      byte_total;

   modport source (output valid, output request_address, output request_length,
                   output request_write, output status, output transaction_total,
                   output byte_total, input ready);
   modport sink (input valid, input request_address, input request_length,
                 input request_write, input status, input transaction_total,
                 input byte_total, output ready);
endinterface
`default_nettype wire

@@ src/dtag_csr.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtag_csr
// Configuration register file, written one register per cycle.
// ----------------------------------------------------------------------------
module dtag_csr (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     csr_write_enable,
   input  wire  [dtag_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  wire  [dtag_pkg::CSR_DATA_BITS-1:0]      csr_write_data,
   output dtag_pkg::cfg_type                       cfg
);

   dtag_pkg::cfg_type cfg_ff;
   dtag_pkg::cfg_type cfg_in;

   // Decode the write into the addressed field
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (dtag_pkg::reg_index_type'(csr_index))
            dtag_pkg::REG_REGION_BASE: begin
               cfg_in.region_base = csr_write_data[dtag_pkg::PORT_ADDR_BITS-1:0];
            end
            dtag_pkg::REG_REGION_SIZE: begin
               cfg_in.region_size = csr_write_data[dtag_pkg::SIZE_BITS-1:0];
            end
            dtag_pkg::REG_TRANSFER_LENGTH: begin
               cfg_in.transfer_length = csr_write_data[dtag_pkg::XFER_BITS-1:0];
            end
            dtag_pkg::REG_WRITE_MODE: begin
               cfg_in.write_mode = csr_write_data[0];
            end
            dtag_pkg::REG_ACCESS_PATTERN: begin
               cfg_in.access_pattern = dtag_pkg::pattern_type'(csr_write_data[1:0]);
            end
            dtag_pkg::REG_ITERATION_LIMIT: begin
               cfg_in.iteration_limit = csr_write_data[dtag_pkg::COUNT_BITS-1:0];
            end
            dtag_pkg::REG_RANDOM_SEED: begin
               cfg_in.random_seed = csr_write_data[dtag_pkg::LFSR_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.region_base     <= '0;
         cfg_ff.region_size     <= dtag_pkg::REGION_SIZE_RST;
         cfg_ff.transfer_length <= dtag_pkg::XFER_LEN_RST;
         cfg_ff.write_mode      <= 1'b0;
         cfg_ff.access_pattern  <= dtag_pkg::PAT_SEQ;
         cfg_ff.iteration_limit <= '0;
         cfg_ff.random_seed     <= dtag_pkg::SEED_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

@@ src/dtag_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtag_ctrl
// Sequencer: accepts a beat, steers the datapath through the start, ignore, fail or
// update step and any remainder and random address steps, then hands the result to the output register.
// ----------------------------------------------------------------------------
module dtag_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  dtag_pkg::sts_type    sts,
   output dtag_pkg::cmd_type    cmd
);

   dtag_pkg::state_type state_ff;
   dtag_pkg::state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dtag_pkg::ST_IDLE: begin
            if (req_valid) state_in = dtag_pkg::ST_EXEC;
         end
         dtag_pkg::ST_EXEC: begin
            if (sts.opcode == dtag_pkg::OPC_COMPLETE && sts.running && !sts.failed &&
                sts.random_div) begin
               state_in = dtag_pkg::ST_DIV;
            end else begin
               state_in = dtag_pkg::ST_EMIT;
            end
         end
         dtag_pkg::ST_DIV: begin
            if (sts.div_last) state_in = dtag_pkg::ST_ADDR;
         end
         dtag_pkg::ST_ADDR: begin
            state_in = dtag_pkg::ST_EMIT;
         end
         dtag_pkg::ST_EMIT: begin
            if (sts.out_free) state_in = dtag_pkg::ST_IDLE;
         end
         default: begin
            state_in = dtag_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_ready   = 1'b0;
      cmd.capture = 1'b0;
      cmd.op      = dtag_pkg::OP_NONE;
      cmd.emit    = 1'b0;
      case (state_ff)
         dtag_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         dtag_pkg::ST_EXEC: begin
            if (sts.opcode == dtag_pkg::OPC_START) begin
               cmd.op = dtag_pkg::OP_START;
            end else if (!sts.running) begin
               cmd.op = dtag_pkg::OP_IGNORE;
            end else if (sts.failed) begin
               cmd.op = dtag_pkg::OP_FAIL;
            end else begin
               cmd.op = dtag_pkg::OP_UPDATE;
            end
         end
         dtag_pkg::ST_DIV: begin
            cmd.op = dtag_pkg::OP_DIV_STEP;
         end
         dtag_pkg::ST_ADDR: begin
            cmd.op = dtag_pkg::OP_RAND_ADDR;
         end
         dtag_pkg::ST_EMIT: begin
            cmd.emit = sts.out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dtag_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

@@ src/dtag_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dtag_dp
// Datapath: run counters, address patterns, LFSR, bit-serial remainder unit
// and the output register.
// ----------------------------------------------------------------------------
module dtag_dp #(
   parameter int READ_CHUNK  = dtag_pkg::READ_CHUNK_DEF,
   parameter int WRITE_CHUNK = dtag_pkg::WRITE_CHUNK_DEF,
   parameter int ADDR_BITS   = dtag_pkg::ADDR_BITS_DEF
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  dtag_pkg::cfg_type                       cfg,
   input  dtag_pkg::cmd_type                       cmd,
   output dtag_pkg::sts_type                       sts,
   input  wire                                     req_opcode,
   input  wire  [dtag_pkg::LEN_BITS-1:0]           req_bytes_done,
   input  wire                                     req_failed,
   output logic                                    rsp_valid,
   input  wire                                     rsp_ready,
   output logic [dtag_pkg::PORT_ADDR_BITS-1:0]     rsp_request_address,
   output logic [dtag_pkg::LEN_BITS-1:0]           rsp_request_length,
   output logic                                    rsp_request_write,
   output logic [1:0]                              rsp_status,
   output logic [dtag_pkg::COUNT_BITS-1:0]         rsp_transaction_total,
   output logic [dtag_pkg::BYTE_BITS-1:0]          rsp_byte_total
);

   localparam int SUM_W = ADDR_BITS + 1;
   localparam int CNT_W = $clog2(dtag_pkg::LFSR_BITS);
   localparam int XB    = dtag_pkg::XFER_BITS;
   localparam logic [XB-1:0] READ_LEN  = XB'(READ_CHUNK);
   localparam logic [XB-1:0] WRITE_LEN = XB'(WRITE_CHUNK);
   localparam logic [XB-1:0] SEQ_STEP  = XB'(dtag_pkg::SEQ512_STEP);

   // Captured beat
   dtag_pkg::opcode_type                 in_opcode_ff, in_opcode_in;
   logic [dtag_pkg::LEN_BITS-1:0]        in_bytes_ff, in_bytes_in;
   logic                                 in_failed_ff, in_failed_in;

   // Run state
   logic [ADDR_BITS-1:0]                 cur_addr_ff, cur_addr_in;
   logic [XB-1:0]                        remain_ff, remain_in;
   logic [dtag_pkg::COUNT_BITS-1:0]      iter_ff, iter_in;
   logic [dtag_pkg::COUNT_BITS-1:0]      txn_ff, txn_in;
   logic [dtag_pkg::BYTE_BITS-1:0]       bytes_ff, bytes_in;
   logic                                 running_ff, running_in;
   logic [dtag_pkg::LFSR_BITS-1:0]       lfsr_ff, lfsr_in;
   dtag_pkg::rsp_status_type             status_ff, status_in;

   // Remainder unit
   logic [dtag_pkg::SIZE_BITS-1:0]       span_ff, span_in;
   logic [dtag_pkg::SIZE_BITS-1:0]       rem_ff, rem_in;
   logic [dtag_pkg::LFSR_BITS-1:0]       dvd_ff, dvd_in;
   logic [CNT_W-1:0]                     div_cnt_ff, div_cnt_in;

   // Output register
   logic                                 out_valid_ff, out_valid_in;
   logic [dtag_pkg::PORT_ADDR_BITS-1:0]  out_addr_ff, out_addr_in;
   logic [dtag_pkg::LEN_BITS-1:0]        out_len_ff, out_len_in;
   logic                                 out_write_ff, out_write_in;
   logic [1:0]                           out_status_ff, out_status_in;
   logic [dtag_pkg::COUNT_BITS-1:0]      out_txn_ff, out_txn_in;
   logic [dtag_pkg::BYTE_BITS-1:0]       out_bytes_ff, out_bytes_in;

   // Helpers
   logic [dtag_pkg::WIDE_BITS-1:0]       base_wide;
   logic [ADDR_BITS-1:0]                 base_addr;
   logic [XB-1:0]                        seq_step;
   logic [SUM_W-1:0]                     seq_lhs;
   logic [SUM_W-1:0]                     seq_rhs;
   logic [ADDR_BITS-1:0]                 seq_addr;
   logic [XB-1:0]                        remain_sub;
   logic                                 random_div;
   logic [dtag_pkg::LFSR_BITS-1:0]       lfsr_step;
   logic [dtag_pkg::SIZE_BITS:0]         div_trial;
   logic                                 div_fit;
   logic [ADDR_BITS-1:0]                 rand_sum;
   logic [XB-1:0]                        chunk;
   logic [XB-1:0]                        req_len;
   logic [dtag_pkg::WIDE_BITS-1:0]       cur_wide;

   // Address arithmetic
   assign base_wide  = dtag_pkg::WIDE_BITS'(cfg.region_base);
   assign base_addr  = base_wide[ADDR_BITS-1:0];
   assign seq_step   = (cfg.access_pattern == dtag_pkg::PAT_SEQ512) ? SEQ_STEP
                                                                     : cfg.transfer_length;
   assign seq_lhs    = SUM_W'(cur_addr_ff) + SUM_W'(seq_step);
   assign seq_rhs    = SUM_W'(base_addr) + SUM_W'(cfg.region_size);
   assign seq_addr   = (seq_lhs > seq_rhs) ? base_addr : seq_lhs[ADDR_BITS-1:0];
   assign remain_sub = (XB'(in_bytes_ff) >= remain_ff) ? '0 : remain_ff - XB'(in_bytes_ff);
   assign random_div = (cfg.access_pattern == dtag_pkg::PAT_RANDOM) &&
                       (cfg.region_size > dtag_pkg::SIZE_BITS'(cfg.transfer_length));
   assign lfsr_step  = dtag_pkg::lfsr_next(lfsr_ff);
   assign rand_sum   = base_addr + ADDR_BITS'(rem_ff);

   // One restoring step of the remainder, dividend bit first from the top
   assign div_trial  = {rem_ff, dvd_ff[dtag_pkg::LFSR_BITS-1]};
   assign div_fit    = div_trial >= {1'b0, span_ff};

   // Request length of the pending chunk
   assign chunk      = cfg.write_mode ? WRITE_LEN : READ_LEN;
   assign req_len    = (remain_ff < chunk) ? remain_ff : chunk;
   assign cur_wide   = dtag_pkg::WIDE_BITS'(cur_addr_ff);

   always_comb begin
      in_opcode_in  = in_opcode_ff;
      in_bytes_in   = in_bytes_ff;
      in_failed_in  = in_failed_ff;
      cur_addr_in   = cur_addr_ff;
      remain_in     = remain_ff;
      iter_in       = iter_ff;
      txn_in        = txn_ff;
      bytes_in      = bytes_ff;
      running_in    = running_ff;
      lfsr_in       = lfsr_ff;
      status_in     = status_ff;
      span_in       = span_ff;
      rem_in        = rem_ff;
      dvd_in        = dvd_ff;
      div_cnt_in    = div_cnt_ff;
      out_addr_in   = out_addr_ff;
      out_len_in    = out_len_ff;
      out_write_in  = out_write_ff;
      out_status_in = out_status_ff;
      out_txn_in    = out_txn_ff;
      out_bytes_in  = out_bytes_ff;

      // Hold the accepted beat
      if (cmd.capture) begin
         in_opcode_in = dtag_pkg::opcode_type'(req_opcode);
         in_bytes_in  = req_bytes_done;
         in_failed_in = req_failed;
      end

      case (cmd.op)
         dtag_pkg::OP_START: begin
            txn_in     = '0;
            bytes_in   = '0;
            cur_addr_in = base_addr;
            remain_in  = cfg.transfer_length;
            iter_in    = cfg.iteration_limit;
            lfsr_in    = (cfg.random_seed != '0) ? cfg.random_seed : dtag_pkg::SEED_RST;
            running_in = 1'b1;
            status_in  = dtag_pkg::STAT_ISSUED;
         end
         dtag_pkg::OP_IGNORE: begin
            status_in = dtag_pkg::STAT_IGNORED;
         end
         dtag_pkg::OP_FAIL: begin
            running_in = 1'b0;
            status_in  = dtag_pkg::STAT_ERROR;
         end
         dtag_pkg::OP_UPDATE: begin
            txn_in   = txn_ff + 1'b1;
            bytes_in = bytes_ff + dtag_pkg::BYTE_BITS'(in_bytes_ff);
            // reload once the transfer is used up
            remain_in = (remain_sub == '0) ? cfg.transfer_length : remain_sub;
            case (cfg.access_pattern)
               dtag_pkg::PAT_SEQ, dtag_pkg::PAT_SEQ512: begin
                  cur_addr_in = seq_addr;
               end
               dtag_pkg::PAT_FIXED: begin
               end
               default: begin
                  if (random_div) begin
                     // advance the LFSR and arm the remainder unit
                     lfsr_in    = lfsr_step;
                     dvd_in     = lfsr_step;
                     rem_in     = '0;
                     span_in    = cfg.region_size - dtag_pkg::SIZE_BITS'(cfg.transfer_length);
                     div_cnt_in = '0;
                  end else begin
                     cur_addr_in = base_addr;
                  end
               end
            endcase
            status_in = dtag_pkg::STAT_ISSUED;
            if (iter_ff != '0) begin
               iter_in = iter_ff - 1'b1;
               if (iter_ff == dtag_pkg::COUNT_BITS'(1)) begin
                  running_in = 1'b0;
                  status_in  = dtag_pkg::STAT_FINISHED;
               end
            end
         end
         dtag_pkg::OP_DIV_STEP: begin
            rem_in     = div_fit ? dtag_pkg::SIZE_BITS'(div_trial - {1'b0, span_ff})
                                 : div_trial[dtag_pkg::SIZE_BITS-1:0];
            dvd_in     = {dvd_ff[dtag_pkg::LFSR_BITS-2:0], 1'b0};
            div_cnt_in = div_cnt_ff + 1'b1;
         end
         dtag_pkg::OP_RAND_ADDR: begin
            cur_addr_in = {rand_sum[ADDR_BITS-1:dtag_pkg::PAGE_BITS],
                           dtag_pkg::PAGE_BITS'(0)};
         end
         default: begin
         end
      endcase

      // Load the result beat; request fields only with an issued request
      if (cmd.emit) begin
         out_status_in = status_ff;
         out_txn_in    = txn_ff;
         out_bytes_in  = bytes_ff;
         if (status_ff == dtag_pkg::STAT_ISSUED) begin
            out_addr_in  = cur_wide[dtag_pkg::PORT_ADDR_BITS-1:0];
            out_len_in   = req_len[dtag_pkg::LEN_BITS-1:0];
            out_write_in = cfg.write_mode;
         end else begin
            out_addr_in  = '0;
            out_len_in   = '0;
            out_write_in = 1'b0;
         end
      end
   end

   // Output beat handshake
   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_valid_ff && rsp_ready) out_valid_in = 1'b0;
      if (cmd.emit) out_valid_in = 1'b1;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         txn_ff       <= '0;
         bytes_ff     <= '0;
         lfsr_ff      <= dtag_pkg::SEED_RST;
         status_ff    <= dtag_pkg::STAT_IGNORED;
         iter_ff      <= '0;
         remain_ff    <= '0;
         cur_addr_ff  <= '0;
      end else begin
         running_ff   <= running_in;
         out_valid_ff <= out_valid_in;
         txn_ff       <= txn_in;
         bytes_ff     <= bytes_in;
         lfsr_ff      <= lfsr_in;
         status_ff    <= status_in;
         iter_ff      <= iter_in;
         remain_ff    <= remain_in;
         cur_addr_ff  <= cur_addr_in;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      in_opcode_ff  <= in_opcode_in;
      in_bytes_ff   <= in_bytes_in;
      in_failed_ff  <= in_failed_in;
      span_ff       <= span_in;
      rem_ff        <= rem_in;
      dvd_ff        <= dvd_in;
      div_cnt_ff    <= div_cnt_in;
      out_addr_ff   <= out_addr_in;
      out_len_ff    <= out_len_in;
      out_write_ff  <= out_write_in;
      out_status_ff <= out_status_in;
      out_txn_ff    <= out_txn_in;
      out_bytes_ff  <= out_bytes_in;
   end

   // Status to the sequencer
   assign sts.opcode     = in_opcode_ff;
   assign sts.failed     = in_failed_ff;
   assign sts.running    = running_ff;
   assign sts.random_div = random_div;
   assign sts.div_last   = (div_cnt_ff == CNT_W'(dtag_pkg::LFSR_BITS - 1));
   assign sts.out_free   = !out_valid_ff || rsp_ready;

   assign rsp_valid             = out_valid_ff;
   assign rsp_request_address   = out_addr_ff;
   assign rsp_request_length    = out_len_ff;
   assign rsp_request_write     = out_write_ff;
   assign rsp_status            = out_status_ff;
   assign rsp_transaction_total = out_txn_ff;
   assign rsp_byte_total        = out_bytes_ff;

endmodule
`default_nettype wire

@@ src/dma_traffic_address_generator.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dma_traffic_address_generator
// DMA benchmark request generator for one requester: start and completion
// beats in, one request or status beat out per beat.
// ----------------------------------------------------------------------------
// Usage: program the registers while the block is idle, then send a start beat
// and one completion beat for every issued request. Each request beat gives
// one response beat. Start, ignored, error and non-random completion beats
// pass the execute and emit states before the next ready; a completion under
// the random pattern also runs the 31-step bit-serial remainder of the LFSR
// value by the region span and the address step. The response sits in an output
// register, so the next request beat is taken while a response still waits.
module dma_traffic_address_generator #(
   parameter int READ_CHUNK  = dtag_pkg::READ_CHUNK_DEF,
   parameter int WRITE_CHUNK = dtag_pkg::WRITE_CHUNK_DEF,
   parameter int ADDR_BITS   = dtag_pkg::ADDR_BITS_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   dtag_req_if.sink                           req_chan,
   dtag_rsp_if.source                         rsp_chan,
   input  wire                                csr_write_enable,
   input  wire  [dtag_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire  [dtag_pkg::CSR_DATA_BITS-1:0] csr_write_data
);

   dtag_pkg::cfg_type cfg;
   dtag_pkg::cmd_type cmd;
   dtag_pkg::sts_type sts;
   logic              req_ready;

   // Register file
   dtag_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // Sequencer
   dtag_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   assign req_chan.ready = req_ready;

   // Datapath
   dtag_dp #(
      .READ_CHUNK  (READ_CHUNK),
      .WRITE_CHUNK (WRITE_CHUNK),
      .ADDR_BITS   (ADDR_BITS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg),
      .cmd                   (cmd),
      .sts                   (sts),
      .req_opcode            (req_chan.opcode),
      .req_bytes_done        (req_chan.bytes_done),
      .req_failed            (req_chan.failed),
      .rsp_valid             (rsp_chan.valid),
      .rsp_ready             (rsp_chan.ready),
      .rsp_request_address   (rsp_chan.request_address),
      .rsp_request_length    (rsp_chan.request_length),
      .rsp_request_write     (rsp_chan.request_write),
      .rsp_status            (rsp_chan.status),
      .rsp_transaction_total (rsp_chan.transaction_total),
      .rsp_byte_total        (rsp_chan.byte_total)
   );

endmodule
`default_nettype wire
